// ===== hw/rtl/spm_pkg.sv =====
package spm_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 15;
    localparam int POS_W   = 16;
    localparam int HT_W    = 15;
    localparam int PCT_W   = 7;
    localparam int PCT_MAX = 100;
    localparam int PCT_MID = 50;

    // ease table format, unsigned fixed point
    localparam int TABLE_FRAC_BITS = 16;
    localparam int SIN_FRAC        = 44;
    localparam int TAYLOR_TERMS    = 20;
    localparam int EASE_W          = TABLE_FRAC_BITS + 1;

    // taylor term divisors, 10000 * 2n * (2n + 1) for term n
    localparam logic [TAYLOR_TERMS:1][31:0] TAYLOR_DIV = {
        32'd16400000, 32'd14820000, 32'd13320000, 32'd11900000, 32'd10560000,
        32'd9300000,  32'd8120000,  32'd7020000,  32'd6000000,  32'd5060000,
        32'd4200000,  32'd3420000,  32'd2720000,  32'd2100000,  32'd1560000,
        32'd1100000,  32'd720000,   32'd420000,   32'd200000,   32'd60000
    };

    // datapath widths
    localparam int NUM_W  = LIFE_W + PCT_W;       // 100 * elapsed, elapsed below life
    localparam int QHI_W  = 4;                    // quotient bits resolved in first divide stage
    localparam int QLO_W  = PCT_W - QHI_W;
    localparam int MAG_W  = POS_W + 1;            // |new - old|
    localparam int PROD_W = EASE_W + MAG_W;
    localparam int LIN_W  = PCT_W + POS_W;        // p * |delta| in linear mode

    // divide by 100 as a multiply by reciprocal, exact below 2**LIN_W
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam longint unsigned RECIP_100_L = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_100_L[RECIP_W-1:0];

    typedef enum logic [1:0] {
        FUNC_LINEAR = 2'd0,
        FUNC_EASE   = 2'd1,
        FUNC_ARC    = 2'd2
    } func_t;

    // item fields that ride along the pipe
    typedef struct packed {
        func_t                    func;
        logic signed [POS_W-1:0]  new_pos;
        logic signed [POS_W-1:0]  old_pos;
        logic [HT_W-1:0]          height;
    } side_t;

    // progress stage result handed to the scaling pipe
    typedef struct packed {
        logic              valid;
        logic [PCT_W-1:0]  progress;
        logic              zero_duration;
        side_t             side;
    } pct_beat_t;

    typedef logic [PCT_MAX:0][EASE_W-1:0] ease_tab_t;

    // half-sine ease table, built at elaboration from a fixed-point taylor series
    function automatic ease_tab_t build_ease_tab();
        ease_tab_t          tab;
        int                 k;
        longint unsigned    mag;
        longint unsigned    term;
        longint unsigned    u;
        longint             sum;
        longint             one;
        tab = '0;
        one = longint'(64'd1 << SIN_FRAC);
        for (int p = 0; p <= PCT_MAX; p++) begin
            k    = (p * 314) / 100 - 157;
            mag  = (k < 0) ? longint'(-k) : longint'(k);
            term = (mag << SIN_FRAC) / 64'd100;
            sum  = longint'(term);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = (term * mag * mag) / TAYLOR_DIV[n];
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (k < 0)
                sum = -sum;
            if (sum < -one)
                sum = -one;
            if (sum > one)
                sum = one;
            u = longint'(sum + one);
            u = (u + (64'd1 << (SIN_FRAC - TABLE_FRAC_BITS))) >> (SIN_FRAC + 1 - TABLE_FRAC_BITS);
            tab[p] = u[EASE_W-1:0];
        end
        return tab;
    endfunction

    localparam ease_tab_t EASE_TAB = build_ease_tab();

endpackage

// ===== hw/rtl/servo_motion_profile.sv =====
// channel   | handshake          | beat fields
// ----------+--------------------+--------------------------------------------------------
// command   | start, busy        | func, now_ms, start_ms, life_ms, new_pos, old_pos,
//           |                    | max_deflection
// result    | done (strobe)      | position, progress, zero_duration
//
// one command beat per clock while busy is low; each taken command gives one result
// through the 8-stage pipe: subtract, compare, two divide stages, table,
// multiply, reciprocal scale, sign/offset
// busy is high only during and right after reset; no clearing pass, nothing is stored
// results cannot be held off, so the pipe never stalls and done is a one-cycle strobe
module servo_motion_profile
    import spm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              func,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic [TIME_W-1:0]       start_ms,
    input  logic [LIFE_W-1:0]       life_ms,
    input  logic signed [POS_W-1:0] new_pos,
    input  logic signed [POS_W-1:0] old_pos,
    input  logic [HT_W-1:0]         max_deflection,
    output logic                    done,
    output logic signed [POS_W-1:0] position,
    output logic [PCT_W-1:0]        progress,
    output logic                    zero_duration
);

    logic      busy_reg;
    logic      accept;
    side_t     side;
    pct_beat_t pct_beat;

    // busy drops on the first edge after reset, so a command is never taken while in reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start & ~busy_reg;

    // fields that are only needed after progress is known
    always_comb
    begin
        side.func    = func_t'(func);
        side.new_pos = new_pos;
        side.old_pos = old_pos;
        side.height  = max_deflection;
    end

    // stages 1-4: elapsed time, clamp test, restoring divide for percent complete
    spm_progress u_progress (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .now_ms   (now_ms),
        .start_ms (start_ms),
        .life_ms  (life_ms),
        .in_side  (side),
        .out_beat (pct_beat)
    );

    // stages 5-8: ease table, multiply, scale back, apply sign and start position
    spm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_beat      (pct_beat),
        .out_valid    (done),
        .out_position (position),
        .out_progress (progress),
        .out_zero     (zero_duration)
    );

endmodule

// ===== hw/rtl/spm_progress.sv =====
module spm_progress
    import spm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] start_ms,
    input  logic [LIFE_W-1:0] life_ms,
    input  side_t             in_side,
    output pct_beat_t         out_beat
);

    // stage 1: elapsed time
    logic              v1_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [LIFE_W-1:0] life1_reg;
    logic              zero1_reg;
    side_t             side1_reg;

    // stage 2: saturation and scaled numerator
    logic              v2_reg;
    logic              sat2_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [LIFE_W-1:0] life2_reg;
    logic              zero2_reg;
    side_t             side2_reg;
    logic              sat2_next;
    logic [NUM_W-1:0]  num2_next;

    // stage 3: upper quotient bits
    logic              v3_reg;
    logic              sat3_reg;
    logic [NUM_W-1:0]  rem3_reg;
    logic [QHI_W-1:0]  qhi3_reg;
    logic [LIFE_W-1:0] life3_reg;
    logic              zero3_reg;
    side_t             side3_reg;
    logic [NUM_W-1:0]  rem3_next;
    logic [QHI_W-1:0]  qhi3_next;
    logic [NUM_W-1:0]  div2;

    // stage 4: lower quotient bits and clamp
    logic              v4_reg;
    logic [PCT_W-1:0]  pct4_reg;
    logic              zero4_reg;
    side_t             side4_reg;
    logic [PCT_W-1:0]  pct4_next;
    logic [NUM_W-1:0]  rem4;
    logic [QLO_W-1:0]  qlo4;
    logic [NUM_W-1:0]  div3;

    always_comb
    begin
        sat2_next = (elapsed_reg >= {{(TIME_W-LIFE_W){1'b0}}, life1_reg});
        num2_next = NUM_W'({{(NUM_W-LIFE_W){1'b0}}, elapsed_reg[LIFE_W-1:0]} * NUM_W'(PCT_MAX));
    end

    assign div2 = {{(NUM_W-LIFE_W){1'b0}}, life2_reg};
    assign div3 = {{(NUM_W-LIFE_W){1'b0}}, life3_reg};

    // restoring divide, quotient bits 6..3
    always_comb
    begin
        rem3_next = num2_reg;
        qhi3_next = '0;
        for (int i = QHI_W - 1; i >= 0; i--)
        begin
            if (rem3_next >= (div2 << (i + QLO_W)))
            begin
                rem3_next    = rem3_next - (div2 << (i + QLO_W));
                qhi3_next[i] = 1'b1;
            end
        end
    end

    // quotient bits 2..0, then clamp once elapsed reaches the duration
    always_comb
    begin
        rem4 = rem3_reg;
        qlo4 = '0;
        for (int i = QLO_W - 1; i >= 0; i--)
        begin
            if (rem4 >= (div3 << i))
            begin
                rem4    = rem4 - (div3 << i);
                qlo4[i] = 1'b1;
            end
        end
        pct4_next = sat3_reg ? PCT_W'(PCT_MAX) : {qhi3_reg, qlo4};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= now_ms - start_ms;
        life1_reg   <= life_ms;
        zero1_reg   <= (life_ms == '0);
        side1_reg   <= in_side;

        sat2_reg  <= sat2_next;
        num2_reg  <= num2_next;
        life2_reg <= life1_reg;
        zero2_reg <= zero1_reg;
        side2_reg <= side1_reg;

        sat3_reg  <= sat2_reg;
        rem3_reg  <= rem3_next;
        qhi3_reg  <= qhi3_next;
        life3_reg <= life2_reg;
        zero3_reg <= zero2_reg;
        side3_reg <= side2_reg;

        pct4_reg  <= pct4_next;
        zero4_reg <= zero3_reg;
        side4_reg <= side3_reg;
    end

    assign out_beat.valid         = v4_reg;
    assign out_beat.progress      = pct4_reg;
    assign out_beat.zero_duration = zero4_reg;
    assign out_beat.side          = side4_reg;

endmodule

// ===== hw/rtl/spm_scale.sv =====
module spm_scale
    import spm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pct_beat_t               in_beat,
    output logic                    out_valid,
    output logic signed [POS_W-1:0] out_position,
    output logic [PCT_W-1:0]        out_progress,
    output logic                    out_zero
);

    // stage 5: table lookup and operand select
    logic                    v5_reg;
    logic [EASE_W-1:0]       opa5_reg;
    logic [MAG_W-1:0]        opb5_reg;
    logic                    neg5_reg;
    logic                    lin5_reg;
    logic signed [POS_W-1:0] base5_reg;
    logic [PCT_W-1:0]        pct5_reg;
    logic                    zero5_reg;
    logic [EASE_W-1:0]       opa5_next;
    logic [MAG_W-1:0]        opb5_next;
    logic                    neg5_next;
    logic                    lin5_next;
    logic signed [POS_W-1:0] base5_next;
    logic [PCT_W-1:0]        dist_mid;
    logic [PCT_W-1:0]        fold;
    logic [PCT_W-1:0]        tab_idx;
    logic [EASE_W-1:0]       ease;
    logic signed [MAG_W-1:0] delta;
    logic [MAG_W-1:0]        delta_mag;

    // stage 6: product
    logic                    v6_reg;
    logic [PROD_W-1:0]       prod6_reg;
    logic                    neg6_reg;
    logic                    lin6_reg;
    logic signed [POS_W-1:0] base6_reg;
    logic [PCT_W-1:0]        pct6_reg;
    logic                    zero6_reg;

    // stage 7: scale down
    logic                    v7_reg;
    logic [MAG_W-1:0]        mag7_reg;
    logic                    neg7_reg;
    logic signed [POS_W-1:0] base7_reg;
    logic [PCT_W-1:0]        pct7_reg;
    logic                    zero7_reg;
    logic [MAG_W-1:0]        mag7_next;
    logic [LIN_W+RECIP_W-1:0] lin_prod;

    // stage 8: sign and offset
    logic                    v8_reg;
    logic signed [POS_W-1:0] pos8_reg;
    logic [PCT_W-1:0]        pct8_reg;
    logic                    zero8_reg;
    logic signed [POS_W-1:0] pos8_next;
    logic signed [MAG_W:0]   sval;
    logic signed [MAG_W:0]   psum;

    always_comb
    begin
        dist_mid  = (in_beat.progress >= PCT_W'(PCT_MID)) ?
                    in_beat.progress - PCT_W'(PCT_MID) : PCT_W'(PCT_MID) - in_beat.progress;
        fold      = (PCT_W'(PCT_MID) - dist_mid) << 1;
        tab_idx   = (in_beat.side.func == FUNC_ARC) ? fold : in_beat.progress;
        ease      = EASE_TAB[tab_idx];
        delta     = {in_beat.side.new_pos[POS_W-1], in_beat.side.new_pos}
                  - {in_beat.side.old_pos[POS_W-1], in_beat.side.old_pos};
        delta_mag = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);

        opa5_next  = '0;
        opb5_next  = '0;
        neg5_next  = 1'b0;
        lin5_next  = 1'b0;
        base5_next = '0;
        case (in_beat.side.func)
            FUNC_LINEAR:
            begin
                opa5_next  = {{(EASE_W-PCT_W){1'b0}}, in_beat.progress};
                opb5_next  = delta_mag;
                neg5_next  = delta[MAG_W-1];
                lin5_next  = 1'b1;
                base5_next = in_beat.side.old_pos;
            end
            FUNC_EASE:
            begin
                opa5_next  = ease;
                opb5_next  = delta_mag;
                neg5_next  = delta[MAG_W-1];
                base5_next = in_beat.side.old_pos;
            end
            FUNC_ARC:
            begin
                opa5_next = ease;
                opb5_next = {{(MAG_W-HT_W){1'b0}}, in_beat.side.height};
            end
            default:
            begin
                opa5_next = '0;
            end
        endcase
    end

    // linear mode divides by 100 through the reciprocal, the others drop the table fraction
    always_comb
    begin
        lin_prod  = {{RECIP_W{1'b0}}, prod6_reg[LIN_W-1:0]} * {{LIN_W{1'b0}}, RECIP_100};
        mag7_next = lin6_reg ? lin_prod[RECIP_SHIFT +: MAG_W]
                             : prod6_reg[TABLE_FRAC_BITS +: MAG_W];
    end

    always_comb
    begin
        sval      = neg7_reg ? -$signed({1'b0, mag7_reg}) : $signed({1'b0, mag7_reg});
        psum      = {{(MAG_W+1-POS_W){base7_reg[POS_W-1]}}, base7_reg} + sval;
        pos8_next = psum[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_beat.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        opa5_reg  <= opa5_next;
        opb5_reg  <= opb5_next;
        neg5_reg  <= neg5_next;
        lin5_reg  <= lin5_next;
        base5_reg <= base5_next;
        pct5_reg  <= in_beat.progress;
        zero5_reg <= in_beat.zero_duration;

        prod6_reg <= {{MAG_W{1'b0}}, opa5_reg} * {{EASE_W{1'b0}}, opb5_reg};
        neg6_reg  <= neg5_reg;
        lin6_reg  <= lin5_reg;
        base6_reg <= base5_reg;
        pct6_reg  <= pct5_reg;
        zero6_reg <= zero5_reg;

        mag7_reg  <= mag7_next;
        neg7_reg  <= neg6_reg;
        base7_reg <= base6_reg;
        pct7_reg  <= pct6_reg;
        zero7_reg <= zero6_reg;

        pos8_reg  <= pos8_next;
        pct8_reg  <= pct7_reg;
        zero8_reg <= zero7_reg;
    end

    assign out_valid    = v8_reg;
    assign out_position = pos8_reg;
    assign out_progress = pct8_reg;
    assign out_zero     = zero8_reg;

endmodule

// ===== hw/rtl/spm_checker.sv =====
module spm_checker
    import spm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    done,
    input  logic signed [POS_W-1:0] position,
    input  logic [PCT_W-1:0]        progress,
    input  logic                    zero_duration
);

    localparam int LATENCY = 8;

    // every accepted command gives a result beat on done
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted command");

    // no result without a matching accepted command
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without command");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (progress <= PCT_W'(PCT_MAX)))
        else $error("progress above 100");

    a_zero_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_duration) |-> (progress == PCT_W'(PCT_MAX)))
        else $error("zero duration without full progress");

    // result fields are fully known while the strobe is up
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({position, progress, zero_duration}))
        else $error("unknown bits on result beat");

endmodule

bind servo_motion_profile spm_checker u_spm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .position      (position),
    .progress      (progress),
    .zero_duration (zero_duration)
);
